// ===== rtl/cda_pkg.sv =====
// Package for the calendar date arithmetic block: field widths, calendar constants,
// month and year length functions, and the structs passed between modules.
// No dependencies.
`default_nettype none

package cda_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 20;
    localparam int CNT_W   = 22;
    localparam int YLEN_W  = 9;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [YLEN_W-1:0]  ylen_t;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DIFF = 1'b1;

    localparam year_t  YEAR_MAX    = 14'd9999;
    localparam month_t MONTH_MAX   = 4'd12;
    localparam day_t   DAY_MAX     = 5'd31;
    // Days from 0001-01-01 to 9999-12-31.
    localparam cnt_t   LAST_SERIAL = 22'd3652058;

    typedef struct packed {
        cnt_t a;
        cnt_t b;
        logic sub;
    } alu_op_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } yr_ctl_t;

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        len = '0;
        if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12})
            len = DAY_MAX;
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = 5'd30;
        else if (m == 4'd2)
            len = leap ? 5'd29 : 5'd28;
        return len;
    endfunction

    function automatic ylen_t year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_arithmetic.sv =====
// Top level of the Gregorian date arithmetic block: sequencer, operand capture and
// result registers. Depends on cda_pkg, cda_alu and cda_year_ctr.
//
// A transaction is taken when start is high and busy is low; busy then stays high
// until the result is shown. The result is on the output ports for one cycle with
// done high and must be taken then. Dates are turned into day counts from
// 0001-01-01 by walking years one per cycle, then months one per cycle, through a
// single shared adder; an add-days transaction walks the sum back the same way.
// A year, month or day of zero, or a year or month past its maximum, sends the
// transaction straight to the finish state; a day past the end of its month is
// caught once the year walk reaches that date's year. The year walk sets the time.
`default_nettype none

module calendar_date_arithmetic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [cda_pkg::YEAR_W-1:0]  base_year,
    input  logic [cda_pkg::MONTH_W-1:0] base_month,
    input  logic [cda_pkg::DAY_W-1:0]   base_day,
    input  logic [cda_pkg::OFF_W-1:0]   offset_days,
    input  logic [cda_pkg::YEAR_W-1:0]  other_year,
    input  logic [cda_pkg::MONTH_W-1:0] other_month,
    input  logic [cda_pkg::DAY_W-1:0]   other_day,
    output logic                        done,
    output logic [cda_pkg::YEAR_W-1:0]  res_year,
    output logic [cda_pkg::MONTH_W-1:0] res_month,
    output logic [cda_pkg::DAY_W-1:0]   new_day,
    output logic [cda_pkg::CNT_W-1:0]   day_count,
    output logic                        year_overflow,
    output logic                        bad_date
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_YEAR   = 4'd1;
    localparam logic [3:0] S_MONTH  = 4'd2;
    localparam logic [3:0] S_DAY    = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_CLAMP  = 4'd5;
    localparam logic [3:0] S_DYEAR  = 4'd6;
    localparam logic [3:0] S_DMONTH = 4'd7;
    localparam logic [3:0] S_DIFF   = 4'd8;
    localparam logic [3:0] S_DNEG   = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    logic            kind_reg, kind_next;
    cda_pkg::year_t  by_reg, by_next, oy_reg, oy_next;
    cda_pkg::month_t bm_reg, bm_next, om_reg, om_next;
    cda_pkg::day_t   bd_reg, bd_next, od_reg, od_next;
    logic [cda_pkg::OFF_W-1:0] off_reg, off_next;
    logic            pass_reg, pass_next;
    cda_pkg::cnt_t   acc_reg, acc_next;
    cda_pkg::cnt_t   ser0_reg, ser0_next;
    cda_pkg::month_t cm_reg, cm_next;
    logic            ovf_reg, ovf_next;
    logic            bad_reg, bad_next;

    cda_pkg::year_t  res_year_reg, res_year_next;
    cda_pkg::month_t res_month_reg, res_month_next;
    cda_pkg::day_t   new_day_reg, new_day_next;
    cda_pkg::cnt_t   day_count_reg, day_count_next;
    logic            year_overflow_reg, year_overflow_next;
    logic            bad_date_reg, bad_date_next;

    cda_pkg::alu_op_t alu_op;
    cda_pkg::cnt_t    alu_res;
    logic             alu_carry;
    cda_pkg::yr_ctl_t yr_ctl;
    cda_pkg::year_t   cur_year;
    logic             cur_leap;

    cda_pkg::year_t  ty;
    cda_pkg::month_t tm;
    cda_pkg::day_t   td;
    logic            base_ok, other_ok;

    cda_alu u_alu (
        .op    (alu_op),
        .res   (alu_res),
        .carry (alu_carry)
    );

    cda_year_ctr u_year (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (yr_ctl),
        .year  (cur_year),
        .leap  (cur_leap)
    );

    assign ty = pass_reg ? oy_reg : by_reg;
    assign tm = pass_reg ? om_reg : bm_reg;
    assign td = pass_reg ? od_reg : bd_reg;

    assign base_ok  = (base_year != '0) && (base_year <= cda_pkg::YEAR_MAX)
                   && (base_month != '0) && (base_month <= cda_pkg::MONTH_MAX)
                   && (base_day != '0);
    assign other_ok = (other_year != '0) && (other_year <= cda_pkg::YEAR_MAX)
                   && (other_month != '0) && (other_month <= cda_pkg::MONTH_MAX)
                   && (other_day != '0);

    always_comb
    begin
        state_next         = state_reg;
        done_next          = 1'b0;
        kind_next          = kind_reg;
        by_next            = by_reg;
        bm_next            = bm_reg;
        bd_next            = bd_reg;
        off_next           = off_reg;
        oy_next            = oy_reg;
        om_next            = om_reg;
        od_next            = od_reg;
        pass_next          = pass_reg;
        acc_next           = acc_reg;
        ser0_next          = ser0_reg;
        cm_next            = cm_reg;
        ovf_next           = ovf_reg;
        bad_next           = bad_reg;
        res_year_next      = res_year_reg;
        res_month_next     = res_month_reg;
        new_day_next       = new_day_reg;
        day_count_next     = day_count_reg;
        year_overflow_next = year_overflow_reg;
        bad_date_next      = bad_date_reg;
        alu_op.a           = acc_reg;
        alu_op.b           = '0;
        alu_op.sub         = 1'b0;
        yr_ctl.clear       = 1'b0;
        yr_ctl.advance     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = kind;
                    by_next      = base_year;
                    bm_next      = base_month;
                    bd_next      = base_day;
                    off_next     = offset_days;
                    oy_next      = other_year;
                    om_next      = other_month;
                    od_next      = other_day;
                    pass_next    = 1'b0;
                    acc_next     = '0;
                    ovf_next     = 1'b0;
                    bad_next     = 1'b0;
                    yr_ctl.clear = 1'b1;
                    if (!base_ok || ((kind == cda_pkg::KIND_DIFF) && !other_ok))
                    begin
                        bad_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (cur_year == ty)
                begin
                    cm_next = 4'd1;
                    if (td > cda_pkg::month_len(tm, cur_leap))
                    begin
                        bad_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_MONTH;
                end
                else
                begin
                    alu_op.b       = cda_pkg::cnt_t'(cda_pkg::year_len(cur_leap));
                    acc_next       = alu_res;
                    yr_ctl.advance = 1'b1;
                end
            end
            S_MONTH:
            begin
                if (cm_reg == tm)
                    state_next = S_DAY;
                else
                begin
                    alu_op.b = cda_pkg::cnt_t'(cda_pkg::month_len(cm_reg, cur_leap));
                    acc_next = alu_res;
                    cm_next  = cm_reg + 4'd1;
                end
            end
            S_DAY:
            begin
                alu_op.b = cda_pkg::cnt_t'(td - 5'd1);
                acc_next = alu_res;
                if (pass_reg)
                    state_next = S_DIFF;
                else if (kind_reg == cda_pkg::KIND_ADD)
                    state_next = S_ADD;
                else
                begin
                    ser0_next    = alu_res;
                    acc_next     = '0;
                    pass_next    = 1'b1;
                    yr_ctl.clear = 1'b1;
                    state_next   = S_YEAR;
                end
            end
            S_ADD:
            begin
                alu_op.b   = cda_pkg::cnt_t'(off_reg);
                acc_next   = alu_res;
                ovf_next   = alu_carry;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                alu_op.a   = cda_pkg::LAST_SERIAL;
                alu_op.b   = acc_reg;
                alu_op.sub = 1'b1;
                if (alu_carry || ovf_reg)
                begin
                    acc_next = cda_pkg::LAST_SERIAL;
                    ovf_next = 1'b1;
                end
                yr_ctl.clear = 1'b1;
                state_next   = S_DYEAR;
            end
            S_DYEAR:
            begin
                alu_op.b   = cda_pkg::cnt_t'(cda_pkg::year_len(cur_leap));
                alu_op.sub = 1'b1;
                if (!alu_carry)
                begin
                    acc_next       = alu_res;
                    yr_ctl.advance = 1'b1;
                end
                else
                begin
                    cm_next    = 4'd1;
                    state_next = S_DMONTH;
                end
            end
            S_DMONTH:
            begin
                alu_op.b   = cda_pkg::cnt_t'(cda_pkg::month_len(cm_reg, cur_leap));
                alu_op.sub = 1'b1;
                if (!alu_carry)
                begin
                    acc_next = alu_res;
                    cm_next  = cm_reg + 4'd1;
                end
                else
                    state_next = S_FIN;
            end
            S_DIFF:
            begin
                alu_op.a   = ser0_reg;
                alu_op.b   = acc_reg;
                alu_op.sub = 1'b1;
                if (!alu_carry)
                begin
                    acc_next   = alu_res;
                    state_next = S_FIN;
                end
                else
                    state_next = S_DNEG;
            end
            S_DNEG:
            begin
                alu_op.b   = ser0_reg;
                alu_op.sub = 1'b1;
                acc_next   = alu_res;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_year_next      = '0;
                res_month_next     = '0;
                new_day_next       = '0;
                day_count_next     = '0;
                year_overflow_next = 1'b0;
                bad_date_next      = bad_reg;
                if (!bad_reg)
                begin
                    if (kind_reg == cda_pkg::KIND_ADD)
                    begin
                        res_year_next      = cur_year;
                        res_month_next     = cm_reg;
                        new_day_next       = acc_reg[cda_pkg::DAY_W-1:0] + 5'd1;
                        year_overflow_next = ovf_reg;
                    end
                    else
                        day_count_next = acc_reg;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg          <= kind_next;
        by_reg            <= by_next;
        bm_reg            <= bm_next;
        bd_reg            <= bd_next;
        off_reg           <= off_next;
        oy_reg            <= oy_next;
        om_reg            <= om_next;
        od_reg            <= od_next;
        pass_reg          <= pass_next;
        acc_reg           <= acc_next;
        ser0_reg          <= ser0_next;
        cm_reg            <= cm_next;
        ovf_reg           <= ovf_next;
        bad_reg           <= bad_next;
        res_year_reg      <= res_year_next;
        res_month_reg     <= res_month_next;
        new_day_reg       <= new_day_next;
        day_count_reg     <= day_count_next;
        year_overflow_reg <= year_overflow_next;
        bad_date_reg      <= bad_date_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign res_year      = res_year_reg;
    assign res_month     = res_month_reg;
    assign new_day       = new_day_reg;
    assign day_count     = day_count_reg;
    assign year_overflow = year_overflow_reg;
    assign bad_date      = bad_date_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_date) |-> (res_year == '0 && day_count == '0 && !year_overflow))
        else $error("invalid date result carries nonzero fields");

    a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
        (done && year_overflow) |->
            (res_year == cda_pkg::YEAR_MAX && res_month == cda_pkg::MONTH_MAX
             && new_day == cda_pkg::DAY_MAX))
        else $error("overflow result not saturated to last date");

    a_decomp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DYEAR) |-> (acc_reg <= cda_pkg::LAST_SERIAL))
        else $error("day count beyond last date during year walk");

endmodule

`default_nettype wire

// ===== rtl/cda_alu.sv =====
// Shared 22-bit add/subtract unit with carry/borrow out.
// Depends on cda_pkg.
`default_nettype none

module cda_alu (
    input  var cda_pkg::alu_op_t op,
    output logic [cda_pkg::CNT_W-1:0] res,
    output logic                      carry
);

    logic [cda_pkg::CNT_W:0] sum;

    always_comb
    begin
        if (op.sub)
            sum = {1'b0, op.a} - {1'b0, op.b};
        else
            sum = {1'b0, op.a} + {1'b0, op.b};
    end

    assign res   = sum[cda_pkg::CNT_W-1:0];
    assign carry = sum[cda_pkg::CNT_W];

endmodule

`default_nettype wire

// ===== rtl/cda_year_ctr.sv =====
// Year walker: current year from 1 upward with its remainders modulo 4, 100 and 400,
// giving the Gregorian leap flag without any division. Depends on cda_pkg.
`default_nettype none

module cda_year_ctr (
    input  logic                       clk,
    input  logic                       rst_n,
    input  var cda_pkg::yr_ctl_t       ctl,
    output logic [cda_pkg::YEAR_W-1:0] year,
    output logic                       leap
);

    logic [cda_pkg::YEAR_W-1:0] year_reg, year_next;
    logic [1:0]                 m4_reg, m4_next;
    logic [6:0]                 m100_reg, m100_next;
    logic [8:0]                 m400_reg, m400_next;

    always_comb
    begin
        year_next = year_reg;
        m4_next   = m4_reg;
        m100_next = m100_reg;
        m400_next = m400_reg;
        if (ctl.clear)
        begin
            year_next = 14'd1;
            m4_next   = 2'd1;
            m100_next = 7'd1;
            m400_next = 9'd1;
        end
        else if (ctl.advance)
        begin
            year_next = year_reg + 14'd1;
            m4_next   = m4_reg + 2'd1;
            m100_next = (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
            m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg <= 14'd1;
            m4_reg   <= 2'd1;
            m100_reg <= 7'd1;
            m400_reg <= 9'd1;
        end
        else
        begin
            year_reg <= year_next;
            m4_reg   <= m4_next;
            m100_reg <= m100_next;
            m400_reg <= m400_next;
        end
    end

    assign year = year_reg;
    assign leap = ((m4_reg == 2'd0) && (m100_reg != 7'd0)) || (m400_reg == 9'd0);

endmodule

`default_nettype wire

// ===== test/tb_calendar_date_arithmetic.sv =====
// Self-checking testbench for calendar_date_arithmetic: directed and random date
// transactions checked against an in-bench Gregorian day-number predictor.
// Depends on cda_pkg and the calendar_date_arithmetic RTL.
`timescale 1ns / 1ps

module tb_calendar_date_arithmetic;

    localparam int   RANDOM_ITEMS = 80;
    localparam int   STALL_LIMIT  = 100000;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   OFF_MAX      = (1 << cda_pkg::OFF_W) - 1;

    typedef struct packed {
        logic              kind;
        cda_pkg::year_t    by;
        cda_pkg::month_t   bm;
        cda_pkg::day_t     bd;
        cda_pkg::off_t     off;
        cda_pkg::year_t    oy;
        cda_pkg::month_t   om;
        cda_pkg::day_t     od;
        int                gap;
        bit                wait_idle;
    } date_req_t;

    typedef struct packed {
        cda_pkg::year_t  yr;
        cda_pkg::month_t mo;
        cda_pkg::day_t   dy;
        cda_pkg::cnt_t   cnt;
        logic            ovf;
        logic            bad;
    } date_res_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              kind = 1'b0;
    cda_pkg::year_t    base_year = '0;
    cda_pkg::month_t   base_month = '0;
    cda_pkg::day_t     base_day = '0;
    cda_pkg::off_t     offset_days = '0;
    cda_pkg::year_t    other_year = '0;
    cda_pkg::month_t   other_month = '0;
    cda_pkg::day_t     other_day = '0;
    logic              busy;
    logic              done;
    cda_pkg::year_t    res_year;
    cda_pkg::month_t   res_month;
    cda_pkg::day_t     new_day;
    cda_pkg::cnt_t     day_count;
    logic              year_overflow;
    logic              bad_date;

    date_req_t pending_q[$];
    date_res_t expected_q[$];
    date_req_t cur_req;
    int        gap_cnt;
    int        stall_cnt;
    int        errors;
    int        n_add;
    int        n_diff;
    int        n_bad;
    int        n_ovf;

    calendar_date_arithmetic u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .base_year    (base_year),
        .base_month   (base_month),
        .base_day     (base_day),
        .offset_days  (offset_days),
        .other_year   (other_year),
        .other_month  (other_month),
        .other_day    (other_day),
        .done         (done),
        .res_year     (res_year),
        .res_month    (res_month),
        .new_day      (new_day),
        .day_count    (day_count),
        .year_overflow(year_overflow),
        .bad_date     (bad_date)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int days_in_month(int m, int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(int y, int m, int d);
        if (y < 1 || y > int'(cda_pkg::YEAR_MAX) || m < 1 || m > 12)
            return 1'b0;
        return d >= 1 && d <= days_in_month(m, y);
    endfunction

    function automatic longint days_before_year(int y);
        longint p;
        p = longint'(y) - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic longint day_number(int y, int m, int d);
        longint n;
        n = days_before_year(y) + longint'(d) - 1;
        for (int k = 1; k < m; k++)
            n += longint'(days_in_month(k, y));
        return n;
    endfunction

    function automatic date_res_t predict_date(date_req_t r);
        date_res_t res;
        longint    s;
        longint    last;
        longint    doy;
        int        y;
        int        m;
        res = '0;
        if (!date_valid(int'(r.by), int'(r.bm), int'(r.bd)) ||
            (r.kind == cda_pkg::KIND_DIFF &&
             !date_valid(int'(r.oy), int'(r.om), int'(r.od))))
        begin
            res.bad = 1'b1;
            return res;
        end
        s = day_number(int'(r.by), int'(r.bm), int'(r.bd));
        if (r.kind == cda_pkg::KIND_DIFF)
        begin
            last = day_number(int'(r.oy), int'(r.om), int'(r.od));
            res.cnt = cda_pkg::cnt_t'((s > last) ? s - last : last - s);
            return res;
        end
        s += longint'(r.off);
        last = day_number(int'(cda_pkg::YEAR_MAX), 12, 31);
        if (s > last)
        begin
            s = last;
            res.ovf = 1'b1;
        end
        y = int'((s * 400) / 146097) + 1;
        while (days_before_year(y + 1) <= s)
            y++;
        while (days_before_year(y) > s)
            y--;
        doy = s - days_before_year(y);
        m = 1;
        while (doy >= longint'(days_in_month(m, y)))
        begin
            doy -= longint'(days_in_month(m, y));
            m++;
        end
        res.yr = cda_pkg::year_t'(y);
        res.mo = cda_pkg::month_t'(m);
        res.dy = cda_pkg::day_t'(doy + 1);
        return res;
    endfunction

    function automatic date_req_t make_req(logic k, int by, int bm, int bd, int off,
                                           int oy, int om, int od);
        date_req_t r;
        r = '0;
        r.kind = k;
        r.by = cda_pkg::year_t'(by);
        r.bm = cda_pkg::month_t'(bm);
        r.bd = cda_pkg::day_t'(bd);
        r.off = cda_pkg::off_t'(off);
        r.oy = cda_pkg::year_t'(oy);
        r.om = cda_pkg::month_t'(om);
        r.od = cda_pkg::day_t'(od);
        return r;
    endfunction

    task automatic pick_date(output cda_pkg::year_t y, output cda_pkg::month_t m,
                             output cda_pkg::day_t d);
        int yy;
        int mm;
        yy = ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 1200)) :
                                          int'($urandom_range(1, 9999));
        mm = int'($urandom_range(1, 12));
        y = cda_pkg::year_t'(yy);
        m = cda_pkg::month_t'(mm);
        d = cda_pkg::day_t'($urandom_range(1, days_in_month(mm, yy)));
    endtask

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: hold start until accepted, then take the next pending transaction.
    always @(posedge clk or negedge rst_n)
    begin : driver
        date_req_t nxt;
        date_res_t want;
        logic      launch;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_cnt <= 0;
        end
        else
        begin
            launch = 1'b0;
            nxt = '0;
            if (start && !busy)
            begin
                want = predict_date(cur_req);
                expected_q.push_back(want);
                if (cur_req.kind == cda_pkg::KIND_ADD)
                    n_add++;
                else
                    n_diff++;
                if (want.bad)
                    n_bad++;
                if (want.ovf)
                    n_ovf++;
            end
            if (!start || !busy)
            begin
                if (pending_q.size() > 0)
                begin
                    if (gap_cnt < pending_q[0].gap)
                        gap_cnt <= gap_cnt + 1;
                    else if (!pending_q[0].wait_idle || expected_q.size() == 0)
                    begin
                        nxt = pending_q.pop_front();
                        launch = 1'b1;
                        gap_cnt <= 0;
                    end
                end
                start <= launch;
                if (launch)
                begin
                    cur_req <= nxt;
                    kind <= nxt.kind;
                    base_year <= nxt.by;
                    base_month <= nxt.bm;
                    base_day <= nxt.bd;
                    offset_days <= nxt.off;
                    other_year <= nxt.oy;
                    other_month <= nxt.om;
                    other_day <= nxt.od;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        date_res_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $time);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("res_year", 64'(want.yr), 64'(res_year));
                check_field("res_month", 64'(want.mo), 64'(res_month));
                check_field("new_day", 64'(want.dy), 64'(new_day));
                check_field("day_count", 64'(want.cnt), 64'(day_count));
                check_field("year_overflow", 64'(want.ovf), 64'(year_overflow));
                check_field("bad_date", 64'(want.bad), 64'(bad_date));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        date_req_t       req;
        cda_pkg::year_t  cy;
        cda_pkg::month_t cm;
        cda_pkg::day_t   cd;
        int              r;
        int              sel;
        bit              use_other;
        errors = 0;
        n_add = 0;
        n_diff = 0;
        n_bad = 0;
        n_ovf = 0;
        stall_cnt = 0;

        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2000, 2, 28, 1, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 1900, 2, 28, 1, 16383, 15, 31));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2024, 12, 31, 1, 0, 0, 0));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 1, 1, 1, 0, 9999, 12, 31));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 1, 1, 1, OFF_MAX, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 9999, 12, 31, 0, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 9999, 12, 31, 1, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 9000, 1, 1, OFF_MAX, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 2023, 6, 15, OFF_MAX, 2023, 6, 15));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 1, 1, 1, 0, 9999, 12, 31));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 9999, 12, 31, 0, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 2004, 3, 1, 0, 2004, 2, 29));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 0, 1, 1, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 16383, 6, 1, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2020, 0, 1, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2020, 15, 1, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2020, 5, 0, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2023, 2, 29, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_ADD, 2021, 4, 31, 5, 1, 1, 1));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 1999, 7, 4, 0, 2000, 2, 30));
        pending_q.push_back(make_req(cda_pkg::KIND_DIFF, 1999, 13, 4, 0, 2000, 2, 29));
        req = make_req(cda_pkg::KIND_DIFF, 1600, 2, 29, 0, 1700, 3, 1);
        req.wait_idle = 1'b1;
        pending_q.push_back(req);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = int'($urandom_range(0, 99));
            req = '0;
            req.kind = 1'($urandom_range(0, 1));
            pick_date(req.by, req.bm, req.bd);
            pick_date(req.oy, req.om, req.od);
            sel = int'($urandom_range(0, 9));
            req.off = (sel < 7) ? cda_pkg::off_t'($urandom_range(0, 4000)) :
                      (sel < 9) ? cda_pkg::off_t'($urandom_range(0, 400000)) :
                                  cda_pkg::off_t'($urandom_range(0, OFF_MAX));
            if (r < 10)
            begin
                req.by = cda_pkg::year_t'($urandom_range(0, 16383));
                req.bm = cda_pkg::month_t'($urandom_range(0, 15));
                req.bd = cda_pkg::day_t'($urandom_range(0, 31));
                req.oy = cda_pkg::year_t'($urandom_range(0, 16383));
                req.om = cda_pkg::month_t'($urandom_range(0, 15));
                req.od = cda_pkg::day_t'($urandom_range(0, 31));
                req.off = cda_pkg::off_t'($urandom_range(0, OFF_MAX));
            end
            else if (r < 20)
            begin
                use_other = (req.kind == cda_pkg::KIND_DIFF) && ($urandom_range(0, 1) == 1);
                {cy, cm, cd} = use_other ? {req.oy, req.om, req.od} : {req.by, req.bm, req.bd};
                case ($urandom_range(0, 5))
                    0: cy = '0;
                    1: cy = cda_pkg::year_t'($urandom_range(10000, 16383));
                    2: cm = '0;
                    3: cm = cda_pkg::month_t'($urandom_range(13, 15));
                    4: cd = '0;
                    default: cd = (days_in_month(int'(cm), int'(cy)) == 31) ? 5'd0 :
                                  cda_pkg::day_t'($urandom_range(
                                      days_in_month(int'(cm), int'(cy)) + 1, 31));
                endcase
                if (use_other)
                    {req.oy, req.om, req.od} = {cy, cm, cd};
                else
                    {req.by, req.bm, req.bd} = {cy, cm, cd};
            end
            else if (r < 23)
            begin
                // Push the sum toward the end of the calendar.
                req.kind = cda_pkg::KIND_ADD;
                req.by = cda_pkg::year_t'($urandom_range(9000, 9999));
                req.off = cda_pkg::off_t'($urandom_range(300000, OFF_MAX));
            end
            sel = int'($urandom_range(0, 99));
            req.gap = (sel < 55) ? 0 : (sel < 90) ? int'($urandom_range(1, 4)) :
                      int'($urandom_range(20, 300));
            req.wait_idle = (i == 0) || ($urandom_range(0, 19) == 0);
            pending_q.push_back(req);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d add-days and %0d days-between transactions", n_add, n_diff);
        $display("of which %0d had an invalid date and %0d saturated at the last year",
                 n_bad, n_ovf);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cda_pkg.sv
rtl/cda_alu.sv
rtl/cda_year_ctr.sv
rtl/calendar_date_arithmetic.sv
test/tb_calendar_date_arithmetic.sv
